/* hdl/pbhg_pkg.sv */
`default_nettype none
package pbhg_pkg;

	// register map, word index = paddr[3:2]
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_HOLD_EN  = 2'd0;
	localparam logic [1:0] REG_BOOT_MS  = 2'd1;
	localparam logic [1:0] REG_OFF_MS   = 2'd2;

	localparam logic [15:0] BOOT_MS_RST = 16'd1000;
	localparam logic [15:0] OFF_MS_RST  = 16'd2000;
	localparam logic [6:0]  PCT_FULL    = 7'd100;
	localparam logic [6:0]  PCT_ZERO    = 7'd0;

	// divider geometry: quotient < 100 fits 7 bits, elapsed*100 fits 23 bits
	localparam int unsigned QUO_W = 7;
	localparam int unsigned NUM_W = 23;
	localparam int unsigned DSH_W = 22;
	localparam logic [2:0]  DIV_LAST = 3'd6;

	typedef enum logic [1:0] {
		REQ_BOOT_RESTART = 2'd0,
		REQ_BOOT_SAMPLE  = 2'd1,
		REQ_OFF_CLEAR    = 2'd2,
		REQ_OFF_SAMPLE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		BOOT_WAITING   = 2'd0,
		BOOT_SATISFIED = 2'd1,
		BOOT_ABORTED   = 2'd2
	} boot_phase_t;

	typedef enum logic [1:0] {
		OFF_IDLE    = 2'd0,
		OFF_HOLDING = 2'd1,
		OFF_READY   = 2'd2
	} off_phase_t;

	typedef enum logic [2:0] {
		EV_NONE           = 3'd0,
		EV_BOOT_ABORTED   = 3'd1,
		EV_BOOT_SATISFIED = 3'd2,
		EV_OFF_STARTED    = 3'd3,
		EV_OFF_PROGRESS   = 3'd4,
		EV_OFF_READY      = 3'd5,
		EV_OFF_CONFIRMED  = 3'd6,
		EV_OFF_CANCELLED  = 3'd7
	} ev_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EVAL = 2'd1,
		ST_DIV  = 2'd2,
		ST_OUT  = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic        hold_to_boot_enabled;
		logic [15:0] boot_hold_ms;
		logic [15:0] off_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

/* hdl/power_button_hold_gate_unit.sv */
// Each accepted input is evaluated and its result loaded into the output
// register; a hold in progress that needs its percentage worked out goes
// through the 7-step divider first. The block takes one item at a time.
// Reset (arst_n low, asynchronous): boot waiting, power-off idle, start times
// zero, registers back to enable=1, boot hold 1000 ms, power-off hold 2000 ms.
`default_nettype none
module power_button_hold_gate_unit
	import pbhg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic               pressed,
	input  wire logic [31:0]        now_ms,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              boot_state,
	output logic [1:0]              off_state,
	output logic [2:0]              event_code,
	output logic [6:0]              progress_percent,
	output logic                    ui_active
);

	cfg_t cfg;

	pbhg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	seq_state_t state_q, state_nxt;

	// captured input transfer
	req_t        req_q;
	logic        pressed_q;
	logic [31:0] now_q;

	// machine state
	boot_phase_t boot_phase_q;
	off_phase_t  off_phase_q;
	logic [31:0] boot_start_q;
	logic [31:0] off_start_q;

	// pending result
	ev_t         ev_q;
	logic [6:0]  pct_q;
	logic        ui_q;

	// result register
	logic        out_valid_q;
	logic [1:0]  boot_out_q;
	logic [1:0]  off_out_q;
	logic [2:0]  ev_out_q;
	logic [6:0]  pct_out_q;
	logic        ui_out_q;

	// evaluation of one request
	boot_phase_t boot_phase_nxt;
	off_phase_t  off_phase_nxt;
	logic [31:0] boot_start_nxt;
	logic [31:0] off_start_nxt;
	ev_t         ev_nxt;
	logic [6:0]  pct_nxt;
	logic        ui_nxt;
	logic        need_div;
	logic [31:0] off_base;
	logic [31:0] boot_elapsed;
	logic [31:0] off_elapsed;

	div_req_t        div_req;
	div_stat_t       div_stat;
	logic [QUO_W-1:0] div_quo;

	logic in_xfer;
	logic out_xfer;
	logic out_load;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	// one item at a time; the previous result may still sit in the output register
	assign in_stall = (state_q != ST_IDLE);

	// a fresh power-off press measures from now, so elapsed starts at zero
	assign off_base     = (off_phase_q == OFF_IDLE) ? now_q : off_start_q;
	assign boot_elapsed = now_q - boot_start_q;
	assign off_elapsed  = now_q - off_base;

	always_comb begin
		boot_phase_nxt = boot_phase_q;
		off_phase_nxt  = off_phase_q;
		boot_start_nxt = boot_start_q;
		off_start_nxt  = off_start_q;
		ev_nxt         = EV_NONE;
		pct_nxt        = PCT_ZERO;
		ui_nxt         = 1'b0;
		need_div       = 1'b0;
		div_req.num    = boot_elapsed[15:0];
		div_req.den    = cfg.boot_hold_ms;

		unique case (req_q)
			REQ_BOOT_RESTART: begin
				boot_start_nxt = now_q;
				boot_phase_nxt = cfg.hold_to_boot_enabled ? BOOT_WAITING : BOOT_SATISFIED;
			end
			REQ_BOOT_SAMPLE: begin
				if (!cfg.hold_to_boot_enabled) begin
					boot_phase_nxt = BOOT_SATISFIED;
					pct_nxt        = PCT_FULL;
				end else if (boot_phase_q != BOOT_WAITING) begin
					pct_nxt = (boot_phase_q == BOOT_SATISFIED) ? PCT_FULL : PCT_ZERO;
				end else if (!pressed_q) begin
					boot_phase_nxt = BOOT_ABORTED;
					ev_nxt         = EV_BOOT_ABORTED;
				end else begin
					ui_nxt = 1'b1;
					if (boot_elapsed >= {16'd0, cfg.boot_hold_ms}) begin
						boot_phase_nxt = BOOT_SATISFIED;
						pct_nxt        = PCT_FULL;
						ev_nxt         = EV_BOOT_SATISFIED;
					end else begin
						// elapsed below a 16-bit hold time, so the low half is exact
						need_div = 1'b1;
					end
				end
			end
			REQ_OFF_CLEAR: begin
				off_start_nxt = '0;
				off_phase_nxt = OFF_IDLE;
			end
			REQ_OFF_SAMPLE: begin
				div_req.num = off_elapsed[15:0];
				div_req.den = cfg.off_hold_ms;
				if (pressed_q) begin
					ui_nxt = 1'b1;
					if (off_phase_q == OFF_IDLE) begin
						off_start_nxt = now_q;
						off_phase_nxt = OFF_HOLDING;
					end
					if (off_elapsed >= {16'd0, cfg.off_hold_ms}) begin
						ev_nxt        = (off_phase_q == OFF_READY) ? EV_OFF_PROGRESS : EV_OFF_READY;
						off_phase_nxt = OFF_READY;
						pct_nxt       = PCT_FULL;
					end else begin
						ev_nxt   = (off_phase_q == OFF_IDLE) ? EV_OFF_STARTED : EV_OFF_PROGRESS;
						need_div = 1'b1;
					end
				end else begin
					if (off_phase_q == OFF_READY) begin
						ev_nxt = EV_OFF_CONFIRMED;
					end else if (off_phase_q == OFF_HOLDING) begin
						ev_nxt = EV_OFF_CANCELLED;
					end
					off_start_nxt = '0;
					off_phase_nxt = OFF_IDLE;
				end
			end
			default: ;
		endcase

		div_req.start = (state_q == ST_EVAL) && need_div;
	end

	pbhg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_nxt = ST_EVAL;
			ST_EVAL: state_nxt = need_div ? ST_DIV : ST_OUT;
			ST_DIV:  if (div_stat.done) state_nxt = ST_OUT;
			ST_OUT:  if (out_load) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q     <= req_t'(req_type);
			pressed_q <= pressed;
			now_q     <= now_ms;
		end
	end

	// machine state commits in the evaluation cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_phase_q <= BOOT_WAITING;
			off_phase_q  <= OFF_IDLE;
			boot_start_q <= '0;
			off_start_q  <= '0;
		end else if (state_q == ST_EVAL) begin
			boot_phase_q <= boot_phase_nxt;
			off_phase_q  <= off_phase_nxt;
			boot_start_q <= boot_start_nxt;
			off_start_q  <= off_start_nxt;
		end
	end

	// pending result; percentage patched in once the divider finishes
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			ev_q  <= ev_nxt;
			pct_q <= pct_nxt;
			ui_q  <= ui_nxt;
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			pct_q <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			boot_out_q <= boot_phase_q;
			off_out_q  <= off_phase_q;
			ev_out_q   <= ev_q;
			pct_out_q  <= pct_q;
			ui_out_q   <= ui_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign boot_state       = boot_out_q;
	assign off_state        = off_out_q;
	assign event_code       = ev_out_q;
	assign progress_percent = pct_out_q;
	assign ui_active        = ui_out_q;

endmodule
`default_nettype wire

/* hdl/pbhg_regs.sv */
`default_nettype none
module pbhg_regs
	import pbhg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_to_boot_enabled <= 1'b1;
			cfg_q.boot_hold_ms         <= BOOT_MS_RST;
			cfg_q.off_hold_ms          <= OFF_MS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HOLD_EN: cfg_q.hold_to_boot_enabled <= pwdata[0];
				REG_BOOT_MS: cfg_q.boot_hold_ms         <= pwdata[15:0];
				REG_OFF_MS:  cfg_q.off_hold_ms          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HOLD_EN: prdata = {31'd0, cfg_q.hold_to_boot_enabled};
			REG_BOOT_MS: prdata = {16'd0, cfg_q.boot_hold_ms};
			REG_OFF_MS:  prdata = {16'd0, cfg_q.off_hold_ms};
			default:     prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/pbhg_div.sv */
`default_nettype none
module pbhg_div
	import pbhg_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  div_req_t    req,
	output div_stat_t   stat,
	output logic [QUO_W-1:0] quo
);

	// restoring divide of num*100 by den, one quotient bit per cycle
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] num_ext;
	logic [NUM_W-1:0] num_x100;
	logic             ge;

	assign num_ext  = {{(NUM_W-16){1'b0}}, req.num};
	assign num_x100 = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
	assign ge       = rem_q >= {1'b0, dsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_x100;
			dsh_q <= {req.den, 6'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule
`default_nettype wire

/* hdl/pbhg_checker.sv */
`default_nettype none
module pbhg_checker
	import pbhg_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [1:0]         boot_state,
	input wire logic [1:0]         off_state,
	input wire logic [2:0]         event_code,
	input wire logic [6:0]         progress_percent,
	input wire logic               ui_active
);

	// an accepted transfer keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still in work");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> progress_percent <= PCT_FULL)
		else $error("progress above 100");

	a_ready_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == EV_OFF_READY) |->
			(progress_percent == PCT_FULL) && (off_state == OFF_READY) && ui_active)
		else $error("ready event without full progress");

	a_release_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((event_code == EV_OFF_CONFIRMED) || (event_code == EV_OFF_CANCELLED)
			|| (event_code == EV_BOOT_ABORTED)) |->
			(progress_percent == PCT_ZERO) && !ui_active)
		else $error("release or abort shows progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code)
			&& $stable(progress_percent) && $stable(boot_state) && $stable(off_state))
		else $error("stalled result changed");

endmodule

bind power_button_hold_gate_unit pbhg_checker u_pbhg_checker (.*);
`default_nettype wire

/* verif/power_button_hold_gate_unit_test.sv */
module power_button_hold_gate_unit_test;
	import pbhg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE      = 16;
	localparam int unsigned PARK_CYCLES = 300;
	localparam int unsigned ROUND_ITEMS = 145;
	localparam int unsigned SHOW_MAX    = 10;

	// one button sample as it goes onto the input channel
	typedef struct packed {
		req_t        req;
		logic        pressed;
		logic [31:0] now;
	} button_sample_t;

	// what the block should answer for that sample
	typedef struct packed {
		boot_phase_t boot;
		off_phase_t  off;
		ev_t         ev;
		logic [6:0]  pct;
		logic        ui;
	} gate_result_t;

	// ---------------------------------------------------------------
	// DUT signals; the ones the bench drives are known from time zero
	// ---------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	req_t               req_type = REQ_BOOT_RESTART;
	logic               pressed = 1'b0;
	logic [31:0]        now_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         boot_state;
	logic [1:0]         off_state;
	logic [2:0]         event_code;
	logic [6:0]         progress_percent;
	logic               ui_active;

	power_button_hold_gate_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.pressed          (pressed),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.boot_state       (boot_state),
		.off_state        (off_state),
		.event_code       (event_code),
		.progress_percent (progress_percent),
		.ui_active        (ui_active)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Testbench state
	// ---------------------------------------------------------------
	button_sample_t sample_queue[$];	// samples waiting for the driver
	gate_result_t   due_results[$];	// answers owed by the block, oldest first
	button_sample_t next_sample;
	gate_result_t   oldest_due;
	logic           sample_taken = 1'b0;
	logic           rx_parked = 1'b0;
	int unsigned    src_gap_pct = 0;
	int unsigned    rx_gap_pct = 0;
	int unsigned    fault_cnt = 0;
	int unsigned    cycle_cnt = 0;
	logic [31:0]    t_ms = '0;	// running clock for well-formed hold sequences
	event           park_rx;

	// predictor's own copy of registers and of both machines
	cfg_t        gate_cfg = '{hold_to_boot_enabled: 1'b1,
	                          boot_hold_ms: BOOT_MS_RST, off_hold_ms: OFF_MS_RST};
	logic [31:0] boot_start = '0;
	boot_phase_t boot_ph = BOOT_WAITING;
	logic [31:0] off_start = '0;
	off_phase_t  off_ph = OFF_IDLE;

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------
	// percent of a hold, floored; full once the hold time is reached or
	// when no hold is asked for at all
	function automatic logic [6:0] hold_percent(input logic [31:0] elapsed,
	                                            input logic [15:0] need);
		logic [63:0] scaled;
		if (need == 16'd0 || elapsed >= {16'd0, need})
			return PCT_FULL;
		scaled = ({32'd0, elapsed} * 64'd100) / {48'd0, need};
		return scaled[6:0];
	endfunction

	// advance both machines by one sample and say what the block answers
	function automatic gate_result_t gate_response(input req_t req, input logic prs,
	                                               input logic [31:0] now);
		gate_result_t r;
		logic [31:0]  elapsed;
		r.ev  = EV_NONE;
		r.pct = PCT_ZERO;
		r.ui  = 1'b0;
		case (req)
			REQ_BOOT_RESTART: begin
				boot_start = now;
				if (gate_cfg.hold_to_boot_enabled)
					boot_ph = BOOT_WAITING;
				else
					boot_ph = BOOT_SATISFIED;
			end
			REQ_BOOT_SAMPLE: begin
				if (!gate_cfg.hold_to_boot_enabled) begin
					// feature off: gate is satisfied whatever the button does
					boot_ph = BOOT_SATISFIED;
					r.pct   = PCT_FULL;
				end else if (boot_ph != BOOT_WAITING) begin
					if (boot_ph == BOOT_SATISFIED)
						r.pct = PCT_FULL;
				end else if (!prs) begin
					boot_ph = BOOT_ABORTED;
					r.ev    = EV_BOOT_ABORTED;
				end else begin
					elapsed = now - boot_start;	// wraps by design
					r.pct   = hold_percent(elapsed, gate_cfg.boot_hold_ms);
					r.ui    = 1'b1;
					if (elapsed >= {16'd0, gate_cfg.boot_hold_ms}) begin
						boot_ph = BOOT_SATISFIED;
						r.pct   = PCT_FULL;
						r.ev    = EV_BOOT_SATISFIED;
					end
				end
			end
			REQ_OFF_CLEAR: begin
				off_start = '0;
				off_ph    = OFF_IDLE;
			end
			default: begin
				if (prs) begin
					if (off_ph == OFF_IDLE) begin
						off_start = now;
						off_ph    = OFF_HOLDING;
						r.ev      = EV_OFF_STARTED;
					end
					elapsed = now - off_start;
					r.pct   = hold_percent(elapsed, gate_cfg.off_hold_ms);
					r.ui    = 1'b1;
					if (elapsed >= {16'd0, gate_cfg.off_hold_ms}) begin
						// start and ready in one go when no hold is needed
						if (off_ph != OFF_READY)
							r.ev = EV_OFF_READY;
						else if (r.ev == EV_NONE)
							r.ev = EV_OFF_PROGRESS;
						off_ph = OFF_READY;
						r.pct  = PCT_FULL;
					end else if (r.ev == EV_NONE) begin
						r.ev = EV_OFF_PROGRESS;
					end
				end else begin
					// release: confirm a ready hold, cancel an unfinished one
					if (off_ph == OFF_READY)
						r.ev = EV_OFF_CONFIRMED;
					else if (off_ph == OFF_HOLDING)
						r.ev = EV_OFF_CANCELLED;
					off_start = '0;
					off_ph    = OFF_IDLE;
				end
			end
		endcase
		r.boot = boot_ph;
		r.off  = off_ph;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Input side: driver changes things on the falling edge, transfers
	// are recognised on the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		sample_taken = arst_n && in_valid && !in_stall;
		if (sample_taken)
			due_results.push_back(gate_response(req_type, pressed, now_ms));
	end

	// the gap decision never looks at in_stall; a stalled sample is held
	always @(negedge clk) begin
		if (!in_valid || sample_taken) begin
			if (sample_queue.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
				next_sample = sample_queue.pop_front();
				req_type <= next_sample.req;
				pressed  <= next_sample.pressed;
				now_ms   <= next_sample.now;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------
	always @(negedge clk)
		out_stall <= rx_parked || ($urandom_range(0, 99) < rx_gap_pct);

	// long hold-off on the result channel so the block backs up into in_stall
	always begin
		@(park_rx);
		rx_parked = 1'b1;
		repeat (PARK_CYCLES) @(negedge clk);
		rx_parked = 1'b0;
	end

	task automatic report_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= SHOW_MAX)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				report_fault("result transfer with no sample outstanding");
			end else begin
				oldest_due = due_results.pop_front();
				if (boot_state !== oldest_due.boot || off_state !== oldest_due.off ||
				    event_code !== oldest_due.ev ||
				    progress_percent !== oldest_due.pct || ui_active !== oldest_due.ui)
					report_fault($sformatf(
						"exp boot=%0d off=%0d ev=%0d pct=%0d ui=%0d, got boot=%0d off=%0d ev=%0d pct=%0d ui=%0d",
						oldest_due.boot, oldest_due.off, oldest_due.ev, oldest_due.pct,
						oldest_due.ui, boot_state, off_state, event_code,
						progress_percent, ui_active));
			end
		end
	end

	// ---------------------------------------------------------------
	// Helpers for the stimulus thread
	// ---------------------------------------------------------------
	function automatic void queue_sample(input req_t req, input logic prs,
	                                     input logic [31:0] now);
		button_sample_t s;
		s.req     = req;
		s.pressed = prs;
		s.now     = now;
		sample_queue.push_back(s);
	endfunction

	// APB write: setup then access; register lands on the pready edge
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HOLD_EN: gate_cfg.hold_to_boot_enabled = data[0];
			REG_BOOT_MS: gate_cfg.boot_hold_ms = data[15:0];
			REG_OFF_MS:  gate_cfg.off_hold_ms = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// junk in the unused upper bits must be dropped by the block
	task automatic apply_setting(input logic en, input logic [15:0] boot_ms,
	                             input logic [15:0] off_ms);
		reg_write(REG_HOLD_EN, {31'($urandom), en});
		reg_write(REG_BOOT_MS, {16'($urandom), boot_ms});
		reg_write(REG_OFF_MS, {16'($urandom), off_ms});
	endtask

	// everything sent, everything answered, then a little slack
	task automatic wait_for_quiet();
		do @(posedge clk);
		while (sample_queue.size() != 0 || in_valid || due_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] hold_step(input logic [15:0] need);
		return $urandom_range(0, need / 3 + 3);
	endfunction

	// mostly real hold sequences with monotonic time, some noise on top
	task automatic queue_random_round(input int unsigned n);
		int unsigned made;
		int unsigned pick;
		int unsigned k;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				t_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);	// straddle the wrap
			if (pick < 35) begin
				queue_sample(REQ_BOOT_RESTART, 1'($urandom_range(0, 1)), t_ms);
				made++;
				k = $urandom_range(1, 6);
				repeat (k) begin
					t_ms += hold_step(gate_cfg.boot_hold_ms);
					queue_sample(REQ_BOOT_SAMPLE, $urandom_range(0, 7) != 0, t_ms);
					made++;
				end
			end else if (pick < 75) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_sample(REQ_OFF_CLEAR, 1'($urandom_range(0, 1)), t_ms);
					made++;
				end
				k = $urandom_range(1, 6);
				repeat (k) begin
					t_ms += hold_step(gate_cfg.off_hold_ms);
					queue_sample(REQ_OFF_SAMPLE, $urandom_range(0, 11) != 0, t_ms);
					made++;
				end
				if ($urandom_range(0, 4) != 0) begin
					t_ms += $urandom_range(0, 20);
					queue_sample(REQ_OFF_SAMPLE, 1'b0, t_ms);
					made++;
				end
			end else begin
				// anything at all, half the time with a wild timestamp
				if ($urandom_range(0, 1) == 0)
					queue_sample(req_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					             $urandom);
				else begin
					t_ms += $urandom_range(0, 50);
					queue_sample(req_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					             t_ms);
				end
				made++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Run watchdog
	// ---------------------------------------------------------------
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_gap_pct = 26;
		rx_gap_pct  = 82;

		// reset settings: boot 1000 ms, power-off 2000 ms, hold required
		queue_sample(REQ_BOOT_SAMPLE, 1'b1, 32'd500);	// waiting from reset, start 0
		queue_sample(REQ_BOOT_RESTART, 1'b1, 32'hFFFF_FF00);
		queue_sample(REQ_BOOT_SAMPLE, 1'b1, 32'h0000_0100);	// elapsed across the wrap
		queue_sample(REQ_BOOT_SAMPLE, 1'b1, 32'h0000_0300);	// satisfied
		queue_sample(REQ_BOOT_SAMPLE, 1'b0, 32'h0000_0400);	// already finished
		queue_sample(REQ_BOOT_RESTART, 1'b0, 32'd0);
		queue_sample(REQ_BOOT_SAMPLE, 1'b0, 32'd5);	// early release aborts
		queue_sample(REQ_BOOT_SAMPLE, 1'b1, 32'd6);	// aborted stays aborted
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'hFFFF_FFFF);
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'h0000_03E7);	// halfway
		queue_sample(REQ_OFF_SAMPLE, 1'b0, 32'h0000_0400);	// cancelled
		queue_sample(REQ_OFF_SAMPLE, 1'b0, 32'h0000_0401);	// release while idle
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd100);
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd2100);	// ready
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd2200);	// still held once ready
		queue_sample(REQ_OFF_SAMPLE, 1'b0, 32'd2300);	// confirmed
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd7);
		queue_sample(REQ_OFF_CLEAR, 1'b1, 32'hFFFF_FFFF);
		queue_sample(REQ_OFF_SAMPLE, 1'b0, 32'd8);
		wait_for_quiet();

		// feature off and zero power-off hold
		apply_setting(1'b0, 16'hFFFF, 16'h0000);
		queue_sample(REQ_BOOT_SAMPLE, 1'b0, 32'hAAAA_AAAA);
		queue_sample(REQ_BOOT_RESTART, 1'b1, 32'h5555_5555);
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd123);	// straight to ready
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd124);
		wait_for_quiet();

		// zero boot hold, longest power-off hold
		apply_setting(1'b1, 16'h0000, 16'hFFFF);
		queue_sample(REQ_BOOT_RESTART, 1'b0, 32'd0);
		queue_sample(REQ_BOOT_SAMPLE, 1'b1, 32'd0);
		queue_sample(REQ_OFF_SAMPLE, 1'b0, 32'd1);
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd0);
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd65534);	// 99 percent
		queue_sample(REQ_OFF_SAMPLE, 1'b1, 32'd65535);
		wait_for_quiet();

		// random part: three idling regimes, three register settings in each
		t_ms = $urandom;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin src_gap_pct = 26; rx_gap_pct = 82; end
				1: begin src_gap_pct = 82; rx_gap_pct = 26; end
				default: begin src_gap_pct = 0; rx_gap_pct = 0; end
			endcase
			for (int rnd = 0; rnd < 3; rnd++) begin
				case (ph * 3 + rnd)
					0: apply_setting(1'b1, BOOT_MS_RST, OFF_MS_RST);
					1: apply_setting(1'b1, 16'h0000, 16'hFFFF);
					2: apply_setting(1'b0, 16'hFFFF, 16'h0000);
					3: apply_setting(1'b1, 16'hFFFF, 16'h0001);
					4: apply_setting(1'b1, 16'($urandom_range(1, 3000)),
					                 16'($urandom_range(1, 3000)));
					5: apply_setting(1'b0, 16'($urandom), 16'($urandom));
					6: apply_setting(1'b1, 16'h0001, 16'hFFFF);
					7: apply_setting(1'b1, 16'($urandom), 16'($urandom));
					default: apply_setting(1'b1, 16'($urandom_range(1, 500)),
					                       16'($urandom_range(1, 500)));
				endcase
				queue_random_round(ROUND_ITEMS);
				// sender flat out while results are held back
				if (ph == 2 && rnd == 0)
					-> park_rx;
				wait_for_quiet();
			end
		end

		if (fault_cnt == 0 && due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* power_button_hold_gate_unit.f */
hdl/pbhg_pkg.sv
hdl/pbhg_regs.sv
hdl/pbhg_div.sv
hdl/power_button_hold_gate_unit.sv
hdl/pbhg_checker.sv
verif/power_button_hold_gate_unit_test.sv
